FILE: hdl/slipd_pkg.sv
package slipd_pkg;

  // slip special characters
  localparam logic [7:0] SLIP_END     = 8'o300;
  localparam logic [7:0] SLIP_ESC     = 8'o333;
  localparam logic [7:0] SLIP_ESC_END = 8'o334;
  localparam logic [7:0] SLIP_ESC_ESC = 8'o335;

  // configuration register
  localparam int unsigned CFG_W = 13;
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  // token queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef enum logic {
    TOK_DATA = 1'b0,
    TOK_END  = 1'b1
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] data;
    logic       ovf;
  } token_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       empty_packet;
    logic       overflow;
  } result_t;

endpackage

FILE: hdl/slipd_front.sv
module slipd_front #(
  parameter int unsigned MAX_PACKET_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [7:0]                  rx_byte,
  input  logic [slipd_pkg::CFG_W-1:0] max_raw_length,
  output logic                        tok_valid,
  output slipd_pkg::token_t           tok
);
  import slipd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_PACKET_BYTES);

  logic             in_packet, in_packet_next;
  logic             escape_pending, escape_pending_next;
  logic [CNT_W-1:0] raw_count, raw_count_next;
  logic             too_long, too_long_next;

  logic             esc_b, tl_b;
  logic [CNT_W-1:0] cnt_b;
  logic [LIM_W-1:0] cfg_ext, limit;

  assign cfg_ext = LIM_W'(max_raw_length);
  assign limit   = (cfg_ext > MAX_LIM) ? MAX_LIM : cfg_ext;

  // an opening byte starts from clean packet state
  assign esc_b = in_packet ? escape_pending : 1'b0;
  assign cnt_b = in_packet ? raw_count : '0;
  assign tl_b  = in_packet ? too_long : 1'b0;

  always_comb begin
    in_packet_next      = in_packet;
    escape_pending_next = escape_pending;
    raw_count_next      = raw_count;
    too_long_next       = too_long;
    tok_valid           = 1'b0;
    tok.kind            = TOK_DATA;
    tok.data            = rx_byte;
    tok.ovf             = 1'b0;
    if (accept) begin
      if (rx_byte == SLIP_END) begin
        if (in_packet) begin
          tok_valid           = 1'b1;
          tok.kind            = TOK_END;
          tok.data            = '0;
          tok.ovf             = too_long;
          in_packet_next      = 1'b0;
          escape_pending_next = 1'b0;
          raw_count_next      = '0;
          too_long_next       = 1'b0;
        end
      end else begin
        in_packet_next      = 1'b1;
        escape_pending_next = esc_b;
        raw_count_next      = cnt_b;
        too_long_next       = tl_b;
        if (LIM_W'(cnt_b) >= limit) begin
          too_long_next = 1'b1;
        end else begin
          raw_count_next = cnt_b + 1'b1;
          if (esc_b) begin
            escape_pending_next = 1'b0;
            if (rx_byte == SLIP_ESC_END) begin
              tok_valid = 1'b1;
              tok.data  = SLIP_END;
            end else if (rx_byte == SLIP_ESC_ESC) begin
              tok_valid = 1'b1;
              tok.data  = SLIP_ESC;
            end
          end else if (rx_byte == SLIP_ESC) begin
            escape_pending_next = 1'b1;
          end else begin
            tok_valid = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet      <= 1'b0;
      escape_pending <= 1'b0;
      raw_count      <= '0;
      too_long       <= 1'b0;
    end else begin
      in_packet      <= in_packet_next;
      escape_pending <= escape_pending_next;
      raw_count      <= raw_count_next;
      too_long       <= too_long_next;
    end
  end

endmodule

FILE: hdl/slipd_queue.sv
module slipd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  slipd_pkg::token_t wr_tok,
  output logic              full,
  output logic              rd_valid,
  output slipd_pkg::token_t rd_tok,
  input  logic              rd_en
);
  import slipd_pkg::*;

  token_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_wr, do_rd;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_tok   = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/slipd_back.sv
module slipd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               tok_valid,
  input  slipd_pkg::token_t  tok,
  output logic               tok_take,
  output logic               res_valid,
  output slipd_pkg::result_t res,
  input  logic               pop
);
  import slipd_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       out_free, emit;
  result_t    res_next;

  assign out_free = !res_valid || pop;
  // a data word with nothing held needs no output slot
  assign tok_take = tok_valid &&
                    (out_free || (tok.kind == TOK_DATA && !held_valid));
  assign emit     = tok_take && (tok.kind == TOK_END || held_valid);

  always_comb begin
    res_next.data_byte    = held_byte;
    res_next.last         = 1'b0;
    res_next.empty_packet = 1'b0;
    res_next.overflow     = 1'b0;
    if (tok.kind == TOK_END) begin
      res_next.last = 1'b1;
      res_next.overflow = tok.ovf;
      if (!held_valid) begin
        res_next.data_byte    = '0;
        res_next.empty_packet = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res <= res_next;
    if (tok_take && tok.kind == TOK_DATA) held_byte <= tok.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (tok_take) held_valid <= (tok.kind == TOK_DATA);
      if (emit) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/slip_frame_decoder_unit.sv
// output: a decoded byte is held until the next decoded byte or the closing END
//   arrives; after that word is accepted it passes the token queue and result reg
// throughput: one input word per cycle while the queue has room, one result word
//   per cycle while popped, set by the byte classifier and the one-word output register
// reset: rst is synchronous; it empties the token queue and result register,
//   drops any open packet and sets max_raw_length back to 4096
module slip_frame_decoder_unit #(
  parameter int unsigned MAX_PACKET_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  // byte input, queue style
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  rx_byte,
  // result output, queue style
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  data_byte,
  output logic                        last,
  output logic                        empty_packet,
  output logic                        overflow,
  // configuration write channel (max_raw_length)
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [slipd_pkg::CFG_W-1:0] cfg_data
);
  import slipd_pkg::*;

  logic [CFG_W-1:0] max_raw_length;

  logic    accept;
  logic    f_tok_valid;
  token_t  f_tok;
  logic    q_valid;
  token_t  q_tok;
  logic    b_take;
  logic    res_valid;
  result_t res;

  // the limit register is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_raw_length <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_raw_length <= cfg_data;
    end
  end

  // a word is taken whenever the token queue has room, even if it makes no token
  assign accept = push && !full;

  // front: escape handling, packet state and the length limit
  slipd_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .rx_byte        (rx_byte),
    .max_raw_length (max_raw_length),
    .tok_valid      (f_tok_valid),
    .tok            (f_tok)
  );

  // short token queue lets the front keep taking bytes while results stall
  slipd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (f_tok_valid),
    .wr_tok   (f_tok),
    .full     (full),
    .rd_valid (q_valid),
    .rd_tok   (q_tok),
    .rd_en    (b_take)
  );

  // back: one-behind hold so the final byte carries last, plus result register
  slipd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_valid),
    .tok       (q_tok),
    .tok_take  (b_take),
    .res_valid (res_valid),
    .res       (res),
    .pop       (pop)
  );

  assign empty        = !res_valid;
  assign data_byte    = res.data_byte;
  assign last         = res.last;
  assign empty_packet = res.empty_packet;
  assign overflow     = res.overflow;

endmodule

FILE: hdl/slipd_checker.sv
module slipd_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] data_byte,
  input logic       last,
  input logic       empty_packet,
  input logic       overflow
);

  // an empty-packet marker always closes a packet
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && empty_packet) |-> last)
    else $error("empty packet marker without last");

  // an empty-packet marker carries a zero byte
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && empty_packet) |-> (data_byte == 8'd0))
    else $error("empty packet marker with nonzero data");

  // overflow is only reported on the closing word
  a_ovf_on_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && overflow) |-> last)
    else $error("overflow flagged before end of packet");

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result pending after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(last)))
    else $error("waiting result changed");

endmodule

bind slip_frame_decoder_unit slipd_checker u_chk (.*);
